// ===== hw/rtl/mtac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtac_pkg
// Shared types and constants for the motion theft alarm controller.
// ----------------------------------------------------------------------------
package mtac_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int SUM_BITS       = 36;
  localparam int TIME_BITS      = 32;
  localparam int MAG_BITS       = 16;
  localparam int REG_BITS       = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [REG_BITS-1:0] GRACE_RST  = 16'd3000;
  localparam logic [REG_BITS-1:0] WINDOW_RST = 16'd7000;
  localparam logic [REG_BITS-1:0] DELTA_RST  = 16'd1434;
  localparam logic [REG_BITS-1:0] BLINK_RST  = 16'd300;
  localparam logic [MAG_BITS-1:0] ONE_G      = 16'd4096;

  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_WHEEL  = 2'd1,
    CAUSE_MOTION = 2'd2
  } cause_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRACE  = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_DELTA  = 2'd2,
    CFG_BLINK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2
  } state_t;

  typedef struct packed {
    logic   is_armed;
    logic   is_triggered;
    cause_t trigger_cause;
    logic   light_update;
    logic   light_on;
    logic   buzzer_update;
    logic   buzzer_on;
    logic   lock_update;
    logic   lock_value;
  } result_t;

  typedef struct packed {
    logic div_start;
    logic commit_eval;
    logic commit_div;
  } seq_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mtac_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtac channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mtac_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic [mtac_pkg::TIME_BITS-1:0]   now_ms;
  logic                             accel_ready;
  logic [mtac_pkg::MAG_BITS-1:0]    accel_magnitude;
  logic [mtac_pkg::TIME_BITS-1:0]   last_wheel_pulse_ms;

  modport source (output valid, operation, now_ms, accel_ready, accel_magnitude,
                  last_wheel_pulse_ms, input ready);
  modport sink   (input valid, operation, now_ms, accel_ready, accel_magnitude,
                  last_wheel_pulse_ms, output ready);
endinterface

interface mtac_out_if;
  logic       valid;
  logic       ready;
  logic       is_armed;
  logic       is_triggered;
  logic [1:0] trigger_cause;
  logic       light_update;
  logic       light_on;
  logic       buzzer_update;
  logic       buzzer_on;
  logic       lock_update;
  logic       lock_value;

  modport source (output valid, is_armed, is_triggered, trigger_cause, light_update,
                  light_on, buzzer_update, buzzer_on, lock_update, lock_value,
                  input ready);
  modport sink   (input valid, is_armed, is_triggered, trigger_cause, light_update,
                  light_on, buzzer_update, buzzer_on, lock_update, lock_value,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mtac_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtac_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtac_div #(
  parameter int NUM_BITS = mtac_pkg::SUM_BITS,
  parameter int DEN_BITS = mtac_pkg::COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] dividend,
  input  wire logic [DEN_BITS-1:0] divisor,
  output logic                     busy,
  output logic [NUM_BITS-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS-1:0] rem;
  logic [NUM_BITS-1:0] quo;
  logic [CNT_BITS-1:0] steps;

  logic [DEN_BITS:0]   rem_shift;
  logic                fits;
  logic [DEN_BITS:0]   rem_sub;

  always_comb begin
    rem_shift = {rem, quo[NUM_BITS-1]};
    fits      = rem_shift >= {1'b0, den};
    rem_sub   = rem_shift - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= CNT_BITS'(NUM_BITS);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (steps != '0) begin
      // remainder stays below the divisor, so the low bits are enough
      rem <= fits ? rem_sub[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end

  assign busy     = steps != '0;
  assign quotient = quo;

endmodule
`default_nettype wire

// ===== hw/rtl/motion_theft_alarm_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motion_theft_alarm_controller
// Arm/disarm/poll alarm with wheel and accelerometer window triggers.
// ----------------------------------------------------------------------------
// Usage: item_in carries arm, disarm or poll requests; result_out returns one
//   result transaction per request. The cfg port writes grace_ms, window_ms,
//   delta_threshold and blink_ms (index 0..3); the user must do so only while
//   the block is idle, which the block itself does not enforce.
// Sequence: a request is registered, the sequencer moves from ST_IDLE to
//   ST_EVAL, and the result enters the output register once ST_EVAL commits.
//   A poll that closes an averaging window runs the restoring divider, one
//   quotient bit per cycle over the 36-bit sum, and ST_DIV writes its result.
//   The block takes one request at a time; the next is accepted once the
//   current result sits in the output register.
// Stalls: while result_out is stalled the result is held; a following
//   request can be accepted but waits before evaluation until the register
//   frees up.
// Reset: rst (synchronous) disarms, clears the window, sets the previous
//   average to 1.0 g and loads the register defaults.
// ----------------------------------------------------------------------------
module motion_theft_alarm_controller #(
  parameter int COUNT_BITS = mtac_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mtac_in_if.sink                                  item_in,
  mtac_out_if.source                               result_out,
  input  wire logic                                cfg_we,
  input  wire logic [mtac_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [mtac_pkg::REG_BITS-1:0]       cfg_data
);

  localparam int SB = mtac_pkg::SUM_BITS;
  localparam int TB = mtac_pkg::TIME_BITS;
  localparam int MB = mtac_pkg::MAG_BITS;
  localparam int RB = mtac_pkg::REG_BITS;

  // configuration
  logic [RB-1:0] grace_ms, window_ms, delta_threshold, blink_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_ms        <= mtac_pkg::GRACE_RST;
      window_ms       <= mtac_pkg::WINDOW_RST;
      delta_threshold <= mtac_pkg::DELTA_RST;
      blink_ms        <= mtac_pkg::BLINK_RST;
    end else if (cfg_we) begin
      case (mtac_pkg::cfg_idx_t'(cfg_index))
        mtac_pkg::CFG_GRACE:  grace_ms        <= cfg_data;
        mtac_pkg::CFG_WINDOW: window_ms       <= cfg_data;
        mtac_pkg::CFG_DELTA:  delta_threshold <= cfg_data;
        mtac_pkg::CFG_BLINK:  blink_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured request
  logic          item_full;
  logic [1:0]    item_op;
  logic [TB-1:0] item_now;
  logic          item_rdy;
  logic [MB-1:0] item_mag;
  logic [TB-1:0] item_wheel;

  // alarm state
  logic                  armed_flag, triggered_flag, blink_level;
  logic [TB-1:0]         armed_time, window_start, last_blink_time, last_buzz_time;
  logic [SB-1:0]         sample_sum;
  logic [COUNT_BITS-1:0] sample_count;
  logic [MB-1:0]         previous_average;

  logic                  armed_flag_next, triggered_flag_next, blink_level_next;
  logic [TB-1:0]         armed_time_next, window_start_next;
  logic [TB-1:0]         last_blink_time_next, last_buzz_time_next;
  logic [SB-1:0]         sample_sum_next;
  logic [COUNT_BITS-1:0] sample_count_next;
  logic [MB-1:0]         previous_average_next;
  logic                  need_div;
  mtac_pkg::result_t     eval_res;

  // output register
  logic              out_valid;
  mtac_pkg::result_t out_res;
  logic              out_free;

  mtac_pkg::state_t  state, state_next;
  mtac_pkg::seq_ctrl_t ctrl;

  logic              div_busy;
  logic [SB-1:0]     div_quo;

  assign out_free     = !out_valid || result_out.ready;
  assign item_in.ready = !item_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      item_full <= 1'b1;
    end else if (ctrl.commit_eval && !need_div || ctrl.commit_div) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      item_op    <= item_in.operation;
      item_now   <= item_in.now_ms;
      item_rdy   <= item_in.accel_ready;
      item_mag   <= item_in.accel_magnitude;
      item_wheel <= item_in.last_wheel_pulse_ms;
    end
  end

  // request evaluation
  logic [TB-1:0] since_arm, since_window, since_blink, since_buzz;
  logic [SB:0]   sum_add;

  always_comb begin
    since_arm    = item_now - armed_time;
    since_window = item_now - window_start;
    since_blink  = item_now - last_blink_time;
    since_buzz   = item_now - last_buzz_time;
    sum_add      = {1'b0, sample_sum} + (SB + 1)'(item_mag);

    armed_flag_next       = armed_flag;
    triggered_flag_next   = triggered_flag;
    blink_level_next      = blink_level;
    armed_time_next       = armed_time;
    window_start_next     = window_start;
    last_blink_time_next  = last_blink_time;
    last_buzz_time_next   = last_buzz_time;
    sample_sum_next       = sample_sum;
    sample_count_next     = sample_count;
    previous_average_next = previous_average;
    need_div              = 1'b0;
    eval_res              = '0;
    eval_res.trigger_cause = mtac_pkg::CAUSE_NONE;

    case (item_op)
      mtac_pkg::OP_ARM: begin
        armed_flag_next       = 1'b1;
        triggered_flag_next   = 1'b0;
        armed_time_next       = item_now;
        window_start_next     = item_now;
        sample_sum_next       = '0;
        sample_count_next     = '0;
        previous_average_next = item_rdy ? item_mag : mtac_pkg::ONE_G;
      end
      mtac_pkg::OP_DISARM: begin
        armed_flag_next        = 1'b0;
        triggered_flag_next    = 1'b0;
        eval_res.buzzer_update = 1'b1;
        eval_res.lock_update   = 1'b1;
      end
      mtac_pkg::OP_POLL: begin
        if (armed_flag) begin
          if (triggered_flag) begin
            if (since_blink >= TB'(blink_ms)) begin
              last_blink_time_next  = item_now;
              blink_level_next      = !blink_level;
              eval_res.light_update = 1'b1;
              eval_res.light_on     = !blink_level;
            end
            if (since_buzz >= TB'(blink_ms)) begin
              last_buzz_time_next    = item_now;
              eval_res.buzzer_update = 1'b1;
              eval_res.buzzer_on     = (since_blink >= TB'(blink_ms)) ? !blink_level
                                                                      : blink_level;
            end
          end else if (since_arm >= TB'(grace_ms)) begin
            if (item_wheel != '0 && item_wheel > armed_time) begin
              triggered_flag_next    = 1'b1;
              eval_res.trigger_cause = mtac_pkg::CAUSE_WHEEL;
              eval_res.lock_update   = 1'b1;
              eval_res.lock_value    = 1'b1;
            end else if (item_rdy) begin
              sample_sum_next   = sum_add[SB] ? '1 : sum_add[SB-1:0];
              sample_count_next = (sample_count == '1) ? sample_count
                                                       : sample_count + 1'b1;
              need_div          = since_window >= TB'(window_ms);
            end
          end
        end
      end
      default: ;
    endcase

    eval_res.is_armed     = armed_flag_next;
    eval_res.is_triggered = triggered_flag_next;
  end

  // window close after division
  logic [MB-1:0]     avg_sat;
  logic [MB-1:0]     avg_delta;
  logic              motion_hit;
  mtac_pkg::result_t div_res;

  always_comb begin
    avg_sat   = (|div_quo[SB-1:MB]) ? '1 : div_quo[MB-1:0];
    avg_delta = (avg_sat > previous_average) ? avg_sat - previous_average
                                             : previous_average - avg_sat;
    motion_hit = avg_delta > delta_threshold;
    div_res                = '0;
    div_res.is_armed       = 1'b1;
    div_res.is_triggered   = motion_hit;
    div_res.trigger_cause  = motion_hit ? mtac_pkg::CAUSE_MOTION : mtac_pkg::CAUSE_NONE;
    div_res.lock_update    = motion_hit;
    div_res.lock_value     = motion_hit;
  end

  mtac_div #(
    .NUM_BITS (SB),
    .DEN_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (sample_sum_next),
    .divisor  (sample_count_next),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mtac_pkg::ST_IDLE: begin
        if (item_full) state_next = mtac_pkg::ST_EVAL;
      end
      mtac_pkg::ST_EVAL: begin
        if (out_free) state_next = need_div ? mtac_pkg::ST_DIV : mtac_pkg::ST_IDLE;
      end
      mtac_pkg::ST_DIV: begin
        if (!div_busy && out_free) state_next = mtac_pkg::ST_IDLE;
      end
      default: state_next = mtac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      mtac_pkg::ST_EVAL: begin
        ctrl.commit_eval = out_free;
        ctrl.div_start   = out_free && need_div;
      end
      mtac_pkg::ST_DIV: begin
        ctrl.commit_div = !div_busy && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag       <= 1'b0;
      triggered_flag   <= 1'b0;
      blink_level      <= 1'b0;
      armed_time       <= '0;
      window_start     <= '0;
      last_blink_time  <= '0;
      last_buzz_time   <= '0;
      sample_sum       <= '0;
      sample_count     <= '0;
      previous_average <= mtac_pkg::ONE_G;
    end else if (ctrl.commit_eval) begin
      armed_flag       <= armed_flag_next;
      triggered_flag   <= triggered_flag_next;
      blink_level      <= blink_level_next;
      armed_time       <= armed_time_next;
      window_start     <= window_start_next;
      last_blink_time  <= last_blink_time_next;
      last_buzz_time   <= last_buzz_time_next;
      sample_sum       <= sample_sum_next;
      sample_count     <= sample_count_next;
      previous_average <= previous_average_next;
    end else if (ctrl.commit_div) begin
      triggered_flag   <= motion_hit;
      previous_average <= avg_sat;
      sample_sum       <= '0;
      sample_count     <= '0;
      window_start     <= item_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit_eval && !need_div || ctrl.commit_div) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit_eval && !need_div) begin
      out_res <= eval_res;
    end else if (ctrl.commit_div) begin
      out_res <= div_res;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.is_armed      = out_res.is_armed;
  assign result_out.is_triggered  = out_res.is_triggered;
  assign result_out.trigger_cause = out_res.trigger_cause;
  assign result_out.light_update  = out_res.light_update;
  assign result_out.light_on      = out_res.light_on;
  assign result_out.buzzer_update = out_res.buzzer_update;
  assign result_out.buzzer_on     = out_res.buzzer_on;
  assign result_out.lock_update   = out_res.lock_update;
  assign result_out.lock_value    = out_res.lock_value;

endmodule
`default_nettype wire

// ===== hw/rtl/mtac_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtac_checker
// Port-level checks on result transactions of the alarm controller.
// ----------------------------------------------------------------------------
module mtac_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       is_armed,
  input wire logic       is_triggered,
  input wire logic [1:0] trigger_cause,
  input wire logic       light_update,
  input wire logic       lock_update,
  input wire logic       lock_value
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trigger_cause) &&
                                $stable(is_triggered) && $stable(lock_value))
    else $error("stalled result changed");

  // a new trigger leaves the alarm armed and triggered and sets the lock
  a_trig_lock: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_cause != mtac_pkg::CAUSE_NONE |->
      is_armed && is_triggered && lock_update && lock_value)
    else $error("trigger without lock");

  // lights only blink while triggered
  a_light: assert property (@(posedge clk) disable iff (rst)
    out_valid && light_update |-> is_armed && is_triggered &&
                                  trigger_cause == mtac_pkg::CAUSE_NONE)
    else $error("light update while not triggered");

  // triggered implies armed; unused cause code never appears
  a_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!is_triggered || is_armed) &&
                  (trigger_cause == mtac_pkg::CAUSE_NONE ||
                   trigger_cause == mtac_pkg::CAUSE_WHEEL ||
                   trigger_cause == mtac_pkg::CAUSE_MOTION))
    else $error("bad result state");

endmodule

bind motion_theft_alarm_controller mtac_checker u_mtac_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .is_armed      (result_out.is_armed),
  .is_triggered  (result_out.is_triggered),
  .trigger_cause (result_out.trigger_cause),
  .light_update  (result_out.light_update),
  .lock_update   (result_out.lock_update),
  .lock_value    (result_out.lock_value)
);
`default_nettype wire
